// ===== rtl/core/rtcseq_pkg.sv =====
// Package: transaction types, device constants and register masks for the RTC sync sequencer.
package rtcseq_pkg;

  localparam int unsigned NumTimeRegs = 7;

  localparam logic [7:0] DevAddr   = 8'hDE;
  localparam logic [7:0] BitSt     = 8'h80;
  localparam logic [7:0] BitOscRun = 8'h20;
  localparam logic [7:0] BitVbat   = 8'h08;

  localparam logic [2:0] RegSecond  = 3'd0;
  localparam logic [2:0] RegWeekday = 3'd3;

  localparam logic [2:0] LenTime   = 3'd7;
  localparam logic [2:0] LenCtrl   = 3'd2;
  localparam logic [2:0] LenStatus = 3'd1;
  localparam logic [2:0] LenAddr   = 3'd1;

  // Masks for second, minute, hour, weekday, day, month, year (byte 0 at the low end)
  localparam logic [NumTimeRegs-1:0][7:0] RegMask =
    {8'hFF, 8'h1F, 8'h3F, 8'h07, 8'h3F, 8'h7F, 8'h7F};

  typedef enum logic [1:0] {
    FuncTick    = 2'd0,
    FuncSetTime = 2'd1,
    FuncLoadRd  = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [6:0] {
    CpReadStart = 7'b0000001,
    CpReadReady = 7'b0000010,
    CpStop      = 7'b0000100,
    CpWaitStop  = 7'b0001000,
    CpUpdate    = 7'b0010000,
    CpStart     = 7'b0100000,
    CpWaitStart = 7'b1000000
  } ctrl_state_e;

  typedef enum logic [3:0] {
    BpIdle  = 4'b0001,
    BpAddr  = 4'b0010,
    BpData  = 4'b0100,
    BpReady = 4'b1000
  } bus_state_e;

  typedef logic [NumTimeRegs-1:0][7:0] bytes7_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        bus_busy;
    logic        bus_failed;
    logic [55:0] read_bytes;
    logic [7:0]  set_second;
    logic [7:0]  set_minute;
    logic [7:0]  set_hour;
    logic [7:0]  set_weekday;
    logic [7:0]  set_day;
    logic [7:0]  set_month;
    logic [7:0]  set_year;
  } in_t;

  typedef struct packed {
    logic        trx_issue;
    logic        trx_write;
    logic        trx_stop;
    logic [2:0]  trx_length;
    logic [55:0] trx_bytes;
    logic        time_ok;
    logic        clock_running;
    logic [55:0] time_now;
  } out_t;

  // One bit per byte lane below the given count
  function automatic logic [NumTimeRegs-1:0] lane_below(input logic [2:0] count);
    logic [NumTimeRegs-1:0] lanes;
    for (int i = 0; i < NumTimeRegs; i++) begin
      lanes[i] = (3'(i) < count);
    end
    return lanes;
  endfunction

endpackage

// ===== rtl/core/rtc_i2c_sync_sequencer_core.sv =====
// Top level: RTC sync sequencer with control and bus state machines and a result register.
// Each accepted transaction runs in a single combinational pass (only a tick steps the
// control and bus machines); its result lands in the output register on the same edge and is
// shown the following cycle. One transaction is taken every cycle: in_ready_o is high
// whenever the output register is empty or its result is being taken in that cycle, so
// the sustained rate is one item per clock, limited only by the downstream ready.
module rtc_i2c_sync_sequencer_core import rtcseq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ctrl_state_e ctrl_q, ctrl_d;
  bus_state_e  bus_q, bus_d;
  bytes7_t     buf_q, buf_d;
  bytes7_t     time_q, time_d;
  logic        time_ok_q, time_ok_d;
  logic        running_q, running_d;
  logic        new_time_q, new_time_d;
  logic        req_pend_q, req_pend_d;
  logic        req_wr_q, req_wr_d;
  logic [2:0]  reg_ptr_q, reg_ptr_d;
  logic [2:0]  count_q, count_d;
  logic        stat_done_q, stat_done_d;

  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        accept;
  bytes7_t     rd_bytes;
  bytes7_t     set_bytes;
  logic [NumTimeRegs-1:0] lanes;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_bytes  = in_data_i.read_bytes;
  assign set_bytes = {in_data_i.set_year, in_data_i.set_month, in_data_i.set_day,
                      in_data_i.set_weekday, in_data_i.set_hour, in_data_i.set_minute,
                      in_data_i.set_second};

  always_comb begin
    ctrl_d      = ctrl_q;
    bus_d       = bus_q;
    buf_d       = buf_q;
    time_d      = time_q;
    time_ok_d   = time_ok_q;
    running_d   = running_q;
    new_time_d  = new_time_q;
    req_pend_d  = req_pend_q;
    req_wr_d    = req_wr_q;
    reg_ptr_d   = reg_ptr_q;
    count_d     = count_q;
    stat_done_d = stat_done_q;
    out_d       = '0;
    lanes       = '0;

    unique case (func_e'(in_data_i.func))
      FuncSetTime: begin
        time_d     = set_bytes;
        new_time_d = 1'b1;
      end
      FuncLoadRd: begin
        lanes = lane_below(count_q);
        for (int i = 0; i < NumTimeRegs; i++) begin
          if (lanes[i]) buf_d[i] = rd_bytes[i];
        end
      end
      FuncTick: begin
        if (bus_q == BpIdle) begin
          unique case (ctrl_q)
            CpReadStart: begin
              req_pend_d = 1'b1;
              req_wr_d   = 1'b0;
              reg_ptr_d  = RegSecond;
              count_d    = LenTime;
              ctrl_d     = CpReadReady;
            end
            CpReadReady: begin
              time_ok_d = !in_data_i.bus_failed;
              if (new_time_q) begin
                ctrl_d = CpStop;
              end else begin
                if (!in_data_i.bus_failed) begin
                  running_d = (buf_q[0] & BitSt) != 8'h00;
                  buf_d     = buf_q & RegMask;
                  time_d    = buf_q & RegMask;
                end
                ctrl_d = CpReadStart;
              end
            end
            CpStop: begin
              req_pend_d  = 1'b1;
              req_wr_d    = 1'b1;
              count_d     = LenCtrl;
              stat_done_d = 1'b0;
              buf_d[0]    = 8'h00;
              buf_d[1]    = 8'h00;
              ctrl_d      = CpWaitStop;
            end
            CpWaitStop: begin
              if (stat_done_q && ((buf_q[0] & BitOscRun) == 8'h00)) begin
                ctrl_d = CpUpdate;
              end else begin
                req_pend_d  = 1'b1;
                req_wr_d    = 1'b0;
                reg_ptr_d   = RegWeekday;
                count_d     = LenStatus;
                stat_done_d = 1'b1;
              end
            end
            CpUpdate: begin
              time_d     = time_q & RegMask;
              req_pend_d = 1'b1;
              req_wr_d   = 1'b1;
              count_d    = LenTime;
              buf_d      = time_q & RegMask;
              buf_d[0]   = 8'h01;
              buf_d[3]   = (time_q[3] & RegMask[3]) | BitVbat;
              ctrl_d     = CpStart;
            end
            CpStart: begin
              req_pend_d  = 1'b1;
              req_wr_d    = 1'b1;
              count_d     = LenCtrl;
              stat_done_d = 1'b0;
              buf_d[0]    = 8'h00;
              buf_d[1]    = time_q[0] | BitSt;
              ctrl_d      = CpWaitStart;
            end
            CpWaitStart: begin
              if (stat_done_q && ((buf_q[0] & BitOscRun) != 8'h00)) begin
                new_time_d = 1'b0;
                ctrl_d     = CpReadStart;
              end else begin
                req_pend_d  = 1'b1;
                req_wr_d    = 1'b0;
                reg_ptr_d   = RegWeekday;
                count_d     = LenStatus;
                stat_done_d = 1'b1;
              end
            end
            default: ctrl_d = CpReadStart;
          endcase
        end

        if (!in_data_i.bus_busy) begin
          unique case (bus_q)
            BpIdle: begin
              if (req_pend_d) begin
                req_pend_d = 1'b0;
                bus_d      = req_wr_d ? BpData : BpAddr;
              end
            end
            BpAddr: begin
              out_d.trx_issue  = 1'b1;
              out_d.trx_write  = 1'b1;
              out_d.trx_length = LenAddr;
              out_d.trx_bytes  = 56'(reg_ptr_q);
              bus_d            = BpData;
            end
            BpData: begin
              out_d.trx_issue  = 1'b1;
              out_d.trx_write  = req_wr_q;
              out_d.trx_stop   = 1'b1;
              out_d.trx_length = count_q;
              lanes            = lane_below(count_q);
              for (int i = 0; i < NumTimeRegs; i++) begin
                out_d.trx_bytes[8*i +: 8] = (lanes[i] && req_wr_q) ? buf_q[i] : 8'h00;
              end
              bus_d = BpReady;
            end
            default: bus_d = BpIdle;
          endcase
        end
      end
      default: ;
    endcase

    out_d.time_ok       = time_ok_d;
    out_d.clock_running = running_d;
    out_d.time_now      = time_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CpReadStart;
      bus_q       <= BpIdle;
      buf_q       <= '0;
      time_q      <= '0;
      time_ok_q   <= 1'b0;
      running_q   <= 1'b0;
      new_time_q  <= 1'b0;
      req_pend_q  <= 1'b0;
      req_wr_q    <= 1'b0;
      reg_ptr_q   <= '0;
      count_q     <= '0;
      stat_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_q      <= ctrl_d;
        bus_q       <= bus_d;
        buf_q       <= buf_d;
        time_q      <= time_d;
        time_ok_q   <= time_ok_d;
        running_q   <= running_d;
        new_time_q  <= new_time_d;
        req_pend_q  <= req_pend_d;
        req_wr_q    <= req_wr_d;
        reg_ptr_q   <= reg_ptr_d;
        count_q     <= count_d;
        stat_done_q <= stat_done_d;
      end
      // hold the result until taken; refill on a new transaction
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule
